// ===== hw/rtl/mm_pkg.sv =====
package mm_pkg;

  localparam int MAX_DIM   = 8;
  localparam int FRAC_BITS = 16;

  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int DATA_W  = 32;
  localparam int PROD_W  = 2 * DATA_W;
  localparam int ACC_W   = PROD_W + $clog2(MAX_DIM);
  localparam int PADDR_W = 4;

  localparam logic [3:0] DIM_RESET = 4'd8;

  localparam logic [1:0] OP_WRITE_A = 2'd0;
  localparam logic [1:0] OP_WRITE_B = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  localparam logic [1:0] REG_A_ROWS     = 2'd0;
  localparam logic [1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [1:0] REG_B_COLS     = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_EMIT
  } mm_state_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic lastk;
  } mm_tag_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [3:0] d);
    logic [DIM_W-1:0] r;
    if (d == 4'd0) begin
      r = DIM_W'(1);
    end else if (32'(d) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(d);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/matrix_multiply_core.sv =====
// Dense product of two stored signed Q16.16 matrices.
// Input channel (in_valid/in_stall): operation 0 or 1 writes element_value
// into A or B at row_index/col_index; operation 2 computes C = A * B with
// the sizes held in the a_rows, inner_size and b_cols registers (APB).
// Load items are taken one per cycle while no compute is in progress. A compute
// item holds in_stall high until its last result has been loaded into the output register.
// Output channel (out_valid/out_stall): results in row-major order, last
// marks the final element. Each element reads A and B through one shared
// multiply-accumulate unit, one product per cycle; the sequencer issues
// the products, waits for the accumulator and then emits the result
// before it starts the next element.
// The output register holds one result; while the receiver stalls, the
// sequencer waits with the next finished element. Load items are accepted
// again once the final result is loaded, also while it waits to be taken.
// Reset sets the size registers to 8 and empties the output register.
// The stores are not cleared: an element must be written before it is used.
module matrix_multiply_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mm_pkg::PADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    operation,
  input  logic [2:0]                    row_index,
  input  logic [2:0]                    col_index,
  input  logic signed [31:0]            element_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_row,
  output logic [2:0]                    out_col,
  output logic signed [31:0]            product_value,
  output logic                          saturated,
  output logic                          last
);
  import mm_pkg::*;

  logic [3:0] a_rows;
  logic [3:0] inner_size;
  logic [3:0] b_cols;

  logic [DIM_W-1:0] rows_n;
  logic [DIM_W-1:0] inner_n;
  logic [DIM_W-1:0] cols_n;

  mm_state_t        state, state_next;
  logic [IDX_W-1:0] i, i_next;
  logic [IDX_W-1:0] j, j_next;
  logic [IDX_W-1:0] k, k_next;

  logic              in_accept;
  logic              wr_ok;
  logic              we_a;
  logic              we_b;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr_a;
  logic [ADDR_W-1:0] raddr_b;
  logic [DATA_W-1:0] rdata_a;
  logic [DATA_W-1:0] rdata_b;

  mm_tag_t           issue;
  logic              mac_done;
  logic [DATA_W-1:0] mac_value;
  logic              mac_sat;

  logic              out_free;
  logic              load_out;
  logic              last_elem;
  logic              last_j;
  logic              lastk;
  logic              cfg_wr;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows     <= DIM_RESET;
      inner_size <= DIM_RESET;
      b_cols     <= DIM_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_A_ROWS:     a_rows     <= pwdata[3:0];
        REG_INNER_SIZE: inner_size <= pwdata[3:0];
        REG_B_COLS:     b_cols     <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_A_ROWS:     prdata = 32'(a_rows);
      REG_INNER_SIZE: prdata = 32'(inner_size);
      REG_B_COLS:     prdata = 32'(b_cols);
      default:        prdata = '0;
    endcase
  end

  assign rows_n  = clamp_dim(a_rows);
  assign inner_n = clamp_dim(inner_size);
  assign cols_n  = clamp_dim(b_cols);

  // element stores
  assign in_accept = in_valid & ~in_stall;
  assign wr_ok     = (32'(row_index) < MAX_DIM) && (32'(col_index) < MAX_DIM);
  assign we_a      = in_accept && wr_ok && (operation == OP_WRITE_A);
  assign we_b      = in_accept && wr_ok && (operation == OP_WRITE_B);
  assign waddr     = ADDR_W'(ADDR_W'(row_index) * ADDR_W'(MAX_DIM) + ADDR_W'(col_index));
  assign raddr_a   = ADDR_W'(ADDR_W'(i) * ADDR_W'(MAX_DIM) + ADDR_W'(k));
  assign raddr_b   = ADDR_W'(ADDR_W'(k) * ADDR_W'(MAX_DIM) + ADDR_W'(j));

  mm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_a_store (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (element_value),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  mm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_b_store (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (element_value),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  mm_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .issue  (issue),
    .a_data (rdata_a),
    .b_data (rdata_b),
    .done   (mac_done),
    .value  (mac_value),
    .sat    (mac_sat)
  );

  // sequencer
  assign lastk     = (DIM_W'(k) + DIM_W'(1)) == inner_n;
  assign last_j    = (DIM_W'(j) + DIM_W'(1)) == cols_n;
  assign last_elem = last_j && ((DIM_W'(i) + DIM_W'(1)) == rows_n);
  assign out_free  = ~out_valid | ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i     <= '0;
      j     <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next  = state;
    i_next      = i;
    j_next      = j;
    k_next      = k;
    in_stall    = 1'b1;
    issue       = '0;
    load_out    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && operation == OP_COMPUTE) begin
          i_next     = '0;
          j_next     = '0;
          k_next     = '0;
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        issue.valid = 1'b1;
        issue.first = (k == '0);
        issue.lastk = lastk;
        if (lastk) begin
          k_next     = '0;
          state_next = ST_WAIT;
        end else begin
          k_next = k + IDX_W'(1);
        end
      end
      ST_WAIT: begin
        if (mac_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          if (last_elem) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_ISSUE;
            if (last_j) begin
              j_next = '0;
              i_next = i + IDX_W'(1);
            end else begin
              j_next = j + IDX_W'(1);
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_row       <= 3'(i);
      out_col       <= 3'(j);
      product_value <= mac_value;
      saturated     <= mac_sat;
      last          <= last_elem;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> state == ST_WAIT)
    else $error("accumulator finished outside the wait state");

  a_end_marked: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) ##1 (state == ST_IDLE) |-> out_valid && last)
    else $error("compute ended without a marked final item");

  a_k_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_ISSUE |-> DIM_W'(k) < inner_n)
    else $error("inner index past inner size");

  a_no_load_over_held: assert property (@(posedge clk) disable iff (rst)
    load_out |-> !(out_valid && out_stall))
    else $error("output register overwritten while stalled");
`endif

endmodule

// ===== hw/rtl/mm_ram.sv =====
module mm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/mm_mac.sv =====
module mm_mac (
  input  logic                         clk,
  input  logic                         rst,
  input  mm_pkg::mm_tag_t              issue,
  input  logic [mm_pkg::DATA_W-1:0]    a_data,
  input  logic [mm_pkg::DATA_W-1:0]    b_data,
  output logic                         done,
  output logic [mm_pkg::DATA_W-1:0]    value,
  output logic                         sat
);
  import mm_pkg::*;

  mm_tag_t                   tag1;
  mm_tag_t                   tag2;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   shifted;
  logic                      fits;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
      done <= 1'b0;
    end else begin
      tag1 <= issue;
      tag2 <= tag1;
      done <= tag2.valid & tag2.lastk;
    end
  end

  always_ff @(posedge clk) begin
    if (tag1.valid) begin
      prod <= $signed(a_data) * $signed(b_data);
    end
    if (tag2.valid) begin
      if (tag2.first) begin
        acc <= ACC_W'(prod);
      end else begin
        acc <= acc + ACC_W'(prod);
      end
    end
  end

  // floor shift, then clip to signed 32 bits
  always_comb begin
    shifted = acc >>> FRAC_BITS;
    fits    = (&shifted[ACC_W-1:DATA_W-1]) | ~(|shifted[ACC_W-1:DATA_W-1]);
    sat     = ~fits;
    if (fits) begin
      value = shifted[DATA_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      value = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      value = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

endmodule
